>>> hdl/deq_pkg.sv
// deq_pkg: shared types, codes and elaboration helpers for the double-ended queue
// used by deq_cell, deq_or_tree and double_ended_queue; depends on nothing else

package deq_pkg;

  localparam int DATA_W        = 64;
  localparam int COUNT_OUT_W   = 7;
  localparam int DEPTH_DEFAULT = 64;
  localparam int TREE_FANIN    = 8;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_APPEND
  } cell_cmd_t;

  typedef enum logic {
    DQ_IDLE,
    DQ_TAIL_WAIT
  } deq_state_t;

  // nodes left after a number of reduction levels
  function automatic int tree_nodes(input int depth, input int level);
    int n;
    n = depth;
    for (int l = 0; l < level; l++) begin
      n = (n + TREE_FANIN - 1) / TREE_FANIN;
    end
    return n;
  endfunction

  // registered levels needed to fold all cells into one word
  function automatic int tree_levels(input int depth);
    int n;
    int l;
    n = TREE_FANIN;
    l = 1;
    while (n < depth) begin
      n = n * TREE_FANIN;
      l = l + 1;
    end
    return l;
  endfunction

endpackage

>>> hdl/deq_cell.sv
// deq_cell: one slot of the queue chain, holds a value and takes from a neighbour
// depends on deq_pkg

module deq_cell #(
  parameter int W   = deq_pkg::DATA_W,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  deq_pkg::cell_cmd_t  cmd,
  input  logic [CW-1:0]       count,
  input  logic [W-1:0]        value,
  input  logic [W-1:0]        prev_data,
  input  logic [W-1:0]        next_data,
  output logic [W-1:0]        data,
  output logic [W-1:0]        tap
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;
  logic         is_tail;

  // tail cell is the one just below the fill level
  assign is_tail = (count == CW'(IDX + 1));

  always_comb begin
    data_nxt = data_r;
    case (cmd)
      deq_pkg::CELL_HOLD:       data_nxt = data_r;
      deq_pkg::CELL_SHIFT_UP:   data_nxt = prev_data;
      deq_pkg::CELL_SHIFT_DOWN: data_nxt = next_data;
      deq_pkg::CELL_APPEND: begin
        if (count == CW'(IDX)) begin
          data_nxt = value;
        end
      end
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap  = is_tail ? data_r : '0;

endmodule

>>> hdl/deq_or_tree.sv
// deq_or_tree: registered or-reduction of the cell taps, fan-in of eight per level
// depends on deq_pkg

module deq_or_tree #(
  parameter int W     = deq_pkg::DATA_W,
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [DEPTH],
  output logic [W-1:0] root
);

  localparam int LEVELS = deq_pkg::tree_levels(DEPTH);
  localparam int FANIN  = deq_pkg::TREE_FANIN;

  logic [W-1:0] tier_r [LEVELS][DEPTH];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int NPREV = deq_pkg::tree_nodes(DEPTH, l - 1);
    localparam int NCUR  = deq_pkg::tree_nodes(DEPTH, l);
    for (genvar j = 0; j < NCUR; j++) begin : g_node
      localparam int KN = (NPREV - j * FANIN < FANIN) ? NPREV - j * FANIN : FANIN;
      logic [W-1:0] merged;
      if (l == 1) begin : g_first
        always_comb begin
          merged = '0;
          for (int k = 0; k < KN; k++) begin
            merged = merged | leaf[j * FANIN + k];
          end
        end
      end else begin : g_upper
        always_comb begin
          merged = '0;
          for (int k = 0; k < KN; k++) begin
            merged = merged | tier_r[l - 2][j * FANIN + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        tier_r[l - 1][j] <= merged;
      end
    end
  end

  assign root = tier_r[LEVELS - 1][0];

endmodule

>>> hdl/double_ended_queue.sv
// double_ended_queue: bounded deque held in a shifting chain of cells
// depends on deq_pkg, deq_cell and deq_or_tree
//
// Usage:
//   A command is taken when start is high and busy is low: in_kind selects push
//   front, push back, pop front or pop back, in_value is the value to push.
//   Every command gives one result, shown for exactly one cycle with out_valid:
//   popped value, status, entry count, front and back values and the empty flag.
//   The front always sits in cell 0 and the queue is packed from there, so a push
//   front shifts the chain up, a pop front shifts it down, a push back writes the
//   cell at the fill level and a pop back only lowers the count.
//   Every command but a pop back that leaves entries behind has its result
//   registered at the accepting edge. That pop back has to find the new
//   back value, which an or-tree of eight-way levels folds out of the chain:
//   busy stays high while the L registered tree levels settle, and the result
//   comes as busy falls, with L = ceil(log8(DEPTH)) (2 for DEPTH = 64).
//   One command a cycle is taken while busy is low.
//   Reset (rst_n low, synchronous) empties the queue; cell contents are not
//   cleared since only occupied cells are ever read.
//   The receiver cannot stall; a result not taken in its cycle is gone.

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [deq_pkg::DATA_W-1:0]        in_value,
  output logic                              out_valid,
  output logic [deq_pkg::DATA_W-1:0]        out_popped_value,
  output logic [1:0]                        out_status,
  output logic [deq_pkg::COUNT_OUT_W-1:0]   out_entry_count,
  output logic [deq_pkg::DATA_W-1:0]        out_front_value,
  output logic [deq_pkg::DATA_W-1:0]        out_back_value,
  output logic                              out_empty_flag
);

  localparam int W      = deq_pkg::DATA_W;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEVELS = deq_pkg::tree_levels(DEPTH);
  localparam int WCW    = $clog2(LEVELS + 1);

  deq_pkg::deq_state_t  state_r, state_nxt;
  logic [WCW-1:0]       wait_cnt_r, wait_cnt_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [W-1:0]         back_r, back_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [W-1:0]         popped_r, popped_nxt;
  deq_pkg::status_t     status_r, status_nxt;
  logic [deq_pkg::COUNT_OUT_W-1:0] count_out_r, count_out_nxt;
  logic [W-1:0]         front_out_r, front_out_nxt;
  logic [W-1:0]         back_out_r, back_out_nxt;
  logic                 empty_out_r, empty_out_nxt;

  deq_pkg::cell_cmd_t   cmd;
  deq_pkg::kind_t       kind;
  logic                 is_full;
  logic                 is_void;
  logic [W-1:0]         front_val;

  logic [W-1:0]         cell_data [DEPTH];
  logic [W-1:0]         cell_tap  [DEPTH];
  logic [W-1:0]         tail_word;

  // chain of cells, cell 0 holds the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] prev_d;
    logic [W-1:0] next_d;
    if (i == 0) begin : g_head
      assign prev_d = in_value;
    end else begin : g_body
      assign prev_d = cell_data[i - 1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign next_d = cell_data[i];
    end else begin : g_mid
      assign next_d = cell_data[i + 1];
    end
    deq_cell #(
      .W   (W),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .value     (in_value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  deq_or_tree #(
    .W     (W),
    .DEPTH (DEPTH)
  ) u_tail (
    .clk  (clk),
    .leaf (cell_tap),
    .root (tail_word)
  );

  assign kind    = deq_pkg::kind_t'(in_kind);
  assign is_full = (count_r == CW'(DEPTH));
  assign is_void = (count_r == '0);

  always_comb begin
    state_nxt     = state_r;
    wait_cnt_nxt  = wait_cnt_r;
    count_nxt     = count_r;
    back_nxt      = back_r;
    out_valid_nxt = 1'b0;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    count_out_nxt = count_out_r;
    front_out_nxt = front_out_r;
    back_out_nxt  = back_out_r;
    empty_out_nxt = empty_out_r;
    cmd           = deq_pkg::CELL_HOLD;
    front_val     = is_void ? '0 : cell_data[0];

    case (state_r)
      deq_pkg::DQ_IDLE: begin
        if (start) begin
          popped_nxt    = '0;
          status_nxt    = deq_pkg::ST_OK;
          out_valid_nxt = 1'b1;
          case (kind)
            deq_pkg::KIND_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = deq_pkg::ST_FULL;
              end else begin
                cmd       = deq_pkg::CELL_SHIFT_UP;
                count_nxt = count_r + CW'(1);
                front_val = in_value;
                if (is_void) begin
                  back_nxt = in_value;
                end
              end
            end
            deq_pkg::KIND_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = deq_pkg::ST_FULL;
              end else begin
                cmd       = deq_pkg::CELL_APPEND;
                count_nxt = count_r + CW'(1);
                back_nxt  = in_value;
                if (is_void) begin
                  front_val = in_value;
                end
              end
            end
            deq_pkg::KIND_POP_FRONT: begin
              if (is_void) begin
                status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                cmd        = deq_pkg::CELL_SHIFT_DOWN;
                popped_nxt = cell_data[0];
                count_nxt  = count_r - CW'(1);
                if (count_r == CW'(1)) begin
                  front_val = '0;
                  back_nxt  = '0;
                end else begin
                  front_val = cell_data[1];
                end
              end
            end
            deq_pkg::KIND_POP_BACK: begin
              if (is_void) begin
                status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                popped_nxt = back_r;
                count_nxt  = count_r - CW'(1);
                if (count_r == CW'(1)) begin
                  front_val = '0;
                  back_nxt  = '0;
                end else begin
                  // new back comes out of the or-tree once it has settled
                  out_valid_nxt = 1'b0;
                  state_nxt     = deq_pkg::DQ_TAIL_WAIT;
                  wait_cnt_nxt  = '0;
                end
              end
            end
            default: begin
              status_nxt = deq_pkg::ST_OK;
            end
          endcase
          front_out_nxt = front_val;
          back_out_nxt  = back_nxt;
          count_out_nxt = deq_pkg::COUNT_OUT_W'(count_nxt);
          empty_out_nxt = (count_nxt == '0);
        end
      end
      deq_pkg::DQ_TAIL_WAIT: begin
        // taps follow the lowered count from the accepting edge, one level per cycle
        if (wait_cnt_r == WCW'(LEVELS)) begin
          back_nxt      = tail_word;
          back_out_nxt  = tail_word;
          out_valid_nxt = 1'b1;
          state_nxt     = deq_pkg::DQ_IDLE;
        end else begin
          wait_cnt_nxt = wait_cnt_r + WCW'(1);
        end
      end
      default: begin
        state_nxt = deq_pkg::DQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::DQ_IDLE;
      wait_cnt_r  <= '0;
      count_r     <= '0;
      back_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      count_r     <= count_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r    <= popped_nxt;
    status_r    <= status_nxt;
    count_out_r <= count_out_nxt;
    front_out_r <= front_out_nxt;
    back_out_r  <= back_out_nxt;
    empty_out_r <= empty_out_nxt;
  end

  assign busy             = (state_r == deq_pkg::DQ_TAIL_WAIT);
  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_entry_count  = count_out_r;
  assign out_front_value  = front_out_r;
  assign out_back_value   = back_out_r;
  assign out_empty_flag   = empty_out_r;

`ifndef SYNTHESIS
  // every accepted transaction either reports next cycle or holds the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction produced neither a result nor busy");

  // the end of a tail search always hands out its result
  a_wait_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("tail search ended without a result");

  // an empty queue reports no front or back value
  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_flag) |->
      (out_front_value == '0 && out_back_value == '0))
    else $error("empty queue reported a front or back value");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds capacity");
`endif

endmodule
